// File: rtl/zbe_pkg.sv
package zbe_pkg;

  // Latitude scale: 65536 steps per degree, one 8 degree band is 2^19 steps
  localparam int unsigned BandShift = 19;

  localparam logic signed [23:0] LAT_S80 = -24'sd5242880;  // -80 degrees
  localparam logic signed [23:0] LAT_N72 = 24'sd4718592;   // 72 degrees
  localparam logic signed [23:0] LAT_N84 = 24'sd5505024;   // 84 degrees
  localparam logic signed [24:0] LAT_OFS = 25'sd5242880;   // +80 degrees

  // Band codes
  localparam logic [4:0] BAND_BELOW = 5'd1;   // north end below band C
  localparam logic [4:0] BAND_C     = 5'd2;
  localparam logic [4:0] BAND_V     = 5'd19;
  localparam logic [4:0] BAND_X     = 5'd21;
  localparam logic [4:0] BAND_ABOVE = 5'd22;  // south end above band X

  // Zones with irregular edges
  localparam logic signed [6:0] ZONE_31 = 7'sd31;
  localparam logic signed [6:0] ZONE_32 = 7'sd32;
  localparam logic signed [6:0] ZONE_33 = 7'sd33;
  localparam logic signed [6:0] ZONE_34 = 7'sd34;
  localparam logic signed [6:0] ZONE_35 = 7'sd35;
  localparam logic signed [6:0] ZONE_36 = 7'sd36;
  localparam logic signed [6:0] ZONE_37 = 7'sd37;

  localparam logic [6:0] ZONE_MAG_MAX = 7'd60;

  typedef struct packed {
    logic [4:0] band;
    logic       south_polar;
    logic       north_polar;
  } band_res_t;

  typedef struct packed {
    logic signed [8:0] cm;
    logic signed [8:0] west;
    logic signed [8:0] east;
    logic signed [7:0] south;
    logic signed [7:0] north;
  } region_t;

endpackage

// File: rtl/mgrs_zone_band_enumerator.sv
// MGRS grid-zone band enumerator.
//
// Input channel (item_valid / item_stall): one transaction carries a signed
// UTM zone and a southern/northern latitude limit in 1/65536 degree.
// Output channel (result_valid / result_stall): one transaction per band
// region touched by the range, south to north, with last set on the final
// one. Where no region exists a single transaction with region_valid low
// and last high is sent. Polar flags ride on every result.
//
// Timing: after acceptance the shared band classifier runs twice (southern
// then northern limit), then the first result is registered from ST_EMIT;
// further regions follow one a cycle while the receiver does not stall.
// A query yields N results (N up to 20), as the sequencer steps one band a
// cycle. item_stall is high from acceptance until the last result is loaded.
//
// Reset (rst, synchronous) returns the sequencer to idle and drops
// result_valid. A stalled receiver holds the result register; the
// sequencer waits on it and no result is lost or repeated.
module mgrs_zone_band_enumerator
  import zbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [6:0]  zone_number,
  input  logic signed [23:0] min_lat,
  input  logic signed [23:0] max_lat,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               region_valid,
  output logic signed [6:0]  zone_out,
  output logic [4:0]         band_index,
  output logic signed [8:0]  central_meridian,
  output logic signed [8:0]  west_edge,
  output logic signed [8:0]  east_edge,
  output logic signed [7:0]  south_edge,
  output logic signed [7:0]  north_edge,
  output logic               south_polar,
  output logic               north_polar,
  output logic               last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SOUTH,
    ST_NORTH,
    ST_EMIT
  } state_t;

  state_t            state;

  // query registers
  logic signed [6:0]  query_zone;
  logic [6:0]         query_mag;
  logic signed [23:0] lo_lat;
  logic signed [23:0] hi_lat;
  logic [4:0]         cur_band;
  logic [4:0]         end_band;
  logic               sp;
  logic               np;

  // shared classifier
  logic signed [23:0] cls_lat;
  logic               cls_north;
  band_res_t          cls_res;
  region_t            region;

  logic               skip_x;
  logic               no_region;
  logic               out_free;
  logic               final_band;

  assign cls_north = (state == ST_NORTH);
  assign cls_lat   = cls_north ? hi_lat : lo_lat;

  zbe_band_unit u_band (
    .lat       (cls_lat),
    .north_end (cls_north),
    .res       (cls_res)
  );

  zbe_region_unit u_region (
    .zone    (query_zone),
    .mag     (query_mag),
    .band    (cur_band),
    .reg_out (region)
  );

  // band X is left out for zones 32, 34 and 36, so the run ends a band early
  assign skip_x = (query_zone == ZONE_32) || (query_zone == ZONE_34) ||
                  (query_zone == ZONE_36);

  assign no_region  = (query_mag == 7'd0) || (query_mag > ZONE_MAG_MAX) ||
                      (cur_band > end_band);
  assign final_band = (cur_band == end_band);
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      // while emitting, the result register is reloaded or held below
      if (state != ST_EMIT && result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            query_zone <= zone_number;
            query_mag  <= zone_number[6] ? 7'(-zone_number) : 7'(zone_number);
            lo_lat     <= min_lat;
            hi_lat     <= max_lat;
            state      <= ST_SOUTH;
          end
        end
        ST_SOUTH: begin
          cur_band <= cls_res.band;
          sp       <= cls_res.south_polar;
          np       <= cls_res.north_polar;
          state    <= ST_NORTH;
        end
        ST_NORTH: begin
          end_band <= (cls_res.band == BAND_X && skip_x) ? BAND_X - 5'd1 : cls_res.band;
          sp       <= sp | cls_res.south_polar;
          np       <= np | cls_res.north_polar;
          state    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            zone_out     <= query_zone;
            south_polar  <= sp;
            north_polar  <= np;
            if (no_region) begin
              region_valid     <= 1'b0;
              band_index       <= '0;
              central_meridian <= '0;
              west_edge        <= '0;
              east_edge        <= '0;
              south_edge       <= '0;
              north_edge       <= '0;
              last             <= 1'b1;
              state            <= ST_IDLE;
            end else begin
              region_valid     <= 1'b1;
              band_index       <= cur_band;
              central_meridian <= region.cm;
              west_edge        <= region.west;
              east_edge        <= region.east;
              south_edge       <= region.south;
              north_edge       <= region.north;
              last             <= final_band;
              cur_band         <= cur_band + 5'd1;
              if (final_band) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/zbe_band_unit.sv
module zbe_band_unit
  import zbe_pkg::*;
(
  input  logic signed [23:0] lat,
  input  logic               north_end,
  output band_res_t          res
);

  logic signed [24:0] off;

  assign off = {lat[23], lat} + LAT_OFS;

  // Floor band membership; an edge latitude goes to the band above, but 84 degrees stays in band X
  always_comb begin
    res = '0;
    if (lat < LAT_S80) begin
      res.south_polar = 1'b1;
      res.band        = north_end ? BAND_BELOW : BAND_C;
    end else if (lat < LAT_N72) begin
      res.band = off[23:BandShift] + BAND_C;
    end else if (lat <= LAT_N84) begin
      res.band = BAND_X;
    end else begin
      res.north_polar = 1'b1;
      res.band        = north_end ? BAND_X : BAND_ABOVE;
    end
  end

endmodule

// File: rtl/zbe_region_unit.sv
module zbe_region_unit
  import zbe_pkg::*;
(
  input  logic signed [6:0] zone,
  input  logic [6:0]        mag,
  input  logic [4:0]        band,
  output region_t           reg_out
);

  logic [9:0]        m6;
  logic signed [9:0] cm;
  logic signed [9:0] w;
  logic signed [9:0] e;
  logic signed [8:0] s;
  logic signed [8:0] nt;

  assign m6 = {1'b0, mag, 2'b00} + {2'b00, mag, 1'b0};
  assign cm = $signed(m6) - 10'sd183;
  assign s  = $signed({1'b0, band, 3'b000}) - 9'sd96;

  always_comb begin
    w  = cm - 10'sd3;
    e  = cm + 10'sd3;
    nt = s + 9'sd8;
    if (band == BAND_X) begin
      nt = s + 9'sd12;
      if (zone == ZONE_31) begin
        e = cm + 10'sd6;
      end else if (zone == ZONE_33 || zone == ZONE_35) begin
        w = cm - 10'sd6;
        e = cm + 10'sd6;
      end else if (zone == ZONE_37) begin
        w = cm - 10'sd6;
      end
    end else if (band == BAND_V) begin
      if (zone == ZONE_31) begin
        e = cm;
      end else if (zone == ZONE_32) begin
        w = cm - 10'sd6;
      end
    end
  end

  assign reg_out.cm    = cm[8:0];
  assign reg_out.west  = w[8:0];
  assign reg_out.east  = e[8:0];
  assign reg_out.south = s[7:0];
  assign reg_out.north = nt[7:0];

endmodule

// File: rtl/zbe_checker.sv
module zbe_checker
  import zbe_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic               region_valid,
  input logic [4:0]         band_index,
  input logic signed [8:0]  west_edge,
  input logic signed [8:0]  east_edge,
  input logic signed [7:0]  south_edge,
  input logic signed [7:0]  north_edge,
  input logic               last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(band_index) &&
      $stable(last) && $stable(region_valid))
    else $error("stalled result changed");

  // an empty answer is a single transaction
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !region_valid |-> last)
    else $error("empty result without last");

  // regions lie within bands C to X and have positive height and width
  a_band: assert property (@(posedge clk) disable iff (rst)
    result_valid && region_valid |->
      band_index >= BAND_C && band_index <= BAND_X && north_edge > south_edge &&
      east_edge > west_edge)
    else $error("region out of shape");

  // no new query is taken while one is open
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> item_stall)
    else $error("query accepted mid-run");

endmodule

bind mgrs_zone_band_enumerator zbe_checker u_zbe_checker (.*);
